// ===== hdl/psma_pkg.sv =====
`default_nettype none

package psma_pkg;

   // Field widths of the request and response channels.
   localparam int OP_W    = 2;
   localparam int ADDR_W  = 32;
   localparam int PSTATE_W = 2;
   localparam int RUN_W   = 17;
   localparam int ERR_W   = 2;

   // Default geometry of the page store.
   localparam int NUM_PAGES_DEF  = 4096;
   localparam int PAGE_BYTES_DEF = 4096;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_SET_PAGE  = 2'd0;
   localparam logic [OP_W-1:0] OP_GET_PAGE  = 2'd1;
   localparam logic [OP_W-1:0] OP_SET_RANGE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLAIM_RUN = 2'd3;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NORUN = 2'd2;

   // Page state codes.
   localparam logic [PSTATE_W-1:0] PS_FREE = 2'd0;
   localparam logic [PSTATE_W-1:0] PS_USED = 2'd1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_START,
      S_DISPATCH,
      S_SET,
      S_GET_RD,
      S_GET_DATA,
      S_DIV_END,
      S_RANGE_CHK,
      S_RANGE,
      S_SCAN,
      S_CLAIM,
      S_MUL,
      S_DONE
   } psma_state_type;

endpackage

`default_nettype wire

// ===== hdl/page_state_map_allocator.sv =====
`default_nettype none

// Set page and get page divide the address by the page size, then write or read that page,
// skipping the access when the page is out of range; set range also divides the end address
// and writes each page from the start page to the one before the end page; claim run scans the
// pages for a free run, marks it used and computes its address, skipping the scan for a zero or oversize run.
// One request at a time; the next can be taken in the cycle after the response loads.
// Reset: synchronous, active high; a clearing pass frees every page.
module page_state_map_allocator #(
   parameter int NUM_PAGES  = psma_pkg::NUM_PAGES_DEF,
   parameter int PAGE_BYTES = psma_pkg::PAGE_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [psma_pkg::OP_W-1:0]     req_operation,
   input  wire logic [psma_pkg::ADDR_W-1:0]   req_address,
   input  wire logic [psma_pkg::ADDR_W-1:0]   req_length,
   input  wire logic [psma_pkg::PSTATE_W-1:0] req_target_state,
   input  wire logic [psma_pkg::RUN_W-1:0]    req_run_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [psma_pkg::PSTATE_W-1:0]      rsp_state_read,
   output logic [psma_pkg::ADDR_W-1:0]        rsp_claim_address,
   output logic [psma_pkg::ERR_W-1:0]         rsp_error_code
);
   import psma_pkg::*;

   // AW indexes the page store; PW also holds NUM_PAGES itself so that counters can
   // run one past the last page. PB_W holds the page size for the multiplier.
   localparam int AW   = $clog2(NUM_PAGES);
   localparam int PW   = $clog2(NUM_PAGES + 1);
   localparam int PB_W = $clog2(PAGE_BYTES + 1);
   localparam int MW   = AW + PB_W;

   // The page number of a 32-bit address x is (x * DIV_M) >> DIV_SH, exact for every x.
   // DIV_M has at most 33 bits: a 32-bit low part and a single top bit.
   localparam int                DIV_SH   = ADDR_W + $clog2(PAGE_BYTES);
   localparam logic [63:0]       DIV_M    =
      ((64'd1 << DIV_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] DIV_M_LO = DIV_M[ADDR_W-1:0];
   localparam logic              DIV_M_HI = DIV_M[ADDR_W];

   localparam logic [ADDR_W-1:0] NP_WIDE  = ADDR_W'(NUM_PAGES);
   localparam logic [PW-1:0]     NP_IDX   = PW'(NUM_PAGES);
   localparam logic [PW-1:0]     LAST_IDX = PW'(NUM_PAGES - 1);

   // The page store: one 2-bit state per entry, synchronous read into a register.
   logic [PSTATE_W-1:0] mem [NUM_PAGES];

   psma_state_type state_ff, state_in;

   // Request held for the whole operation.
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   len_ff, len_in;
   logic [PSTATE_W-1:0] nst_ff, nst_in;
   logic [RUN_W-1:0]    cnt_ff, cnt_in;

   // Division by the page size: the product of the dividend and the low part of the reciprocal
   // is registered first, then the top part is added and the sum is shifted.
   logic [ADDR_W-1:0]   dq_ff, dq_in;
   logic [2*ADDR_W-1:0] prod_ff, prod_in;
   logic                step_ff, step_in;
   logic [2*ADDR_W:0]   div_sum;
   logic [ADDR_W-1:0]   div_q;

   // Start and end page of the operation.
   logic [ADDR_W-1:0] page_ff, page_in;
   logic [ADDR_W-1:0] last_ff, last_in;

   // Shared page counter: clearing pass, range writes, scan reads and run marking.
   logic [PW-1:0] idx_ff, idx_in;

   // Scan pipeline: the entry read in the previous cycle and the current free run.
   logic [AW-1:0]    scan_d_ff, scan_d_in;
   logic             dv_ff, dv_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic [RUN_W-1:0] run_next;
   logic             run_hit;
   logic [PW-1:0]    scan_start;
   logic [AW-1:0]    start_ff, start_in;
   logic [RUN_W-1:0] left_ff, left_in;
   logic [MW-1:0]    claim_prod;

   logic [PSTATE_W-1:0] rd_data_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [PSTATE_W-1:0] mem_wdata;
   logic [AW-1:0]       mem_raddr;

   // Result being assembled, then the response register.
   logic [PSTATE_W-1:0] res_state_ff, res_state_in;
   logic [ADDR_W-1:0]   res_claim_ff, res_claim_in;
   logic [ERR_W-1:0]    res_err_ff, res_err_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PSTATE_W-1:0] rsp_state_ff, rsp_state_in;
   logic [ADDR_W-1:0]   rsp_claim_ff, rsp_claim_in;
   logic [ERR_W-1:0]    rsp_err_ff, rsp_err_in;

   logic req_take;
   logic rsp_free;
   logic page_bad;
   logic cnt_too_big;

   assign req_take    = (state_ff == S_IDLE) && req_valid;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign page_bad    = page_ff >= NP_WIDE;
   assign cnt_too_big = ADDR_W'(req_run_length) > NP_WIDE;

   assign prod_in = (2*ADDR_W)'(dq_ff) * (2*ADDR_W)'(DIV_M_LO);
   assign div_sum = {1'b0, prod_ff} + (DIV_M_HI ? {1'b0, dq_ff, {ADDR_W{1'b0}}} : '0);
   assign div_q   = ADDR_W'(div_sum >> DIV_SH);

   assign run_next   = (rd_data_ff == PS_FREE) ? run_ff + RUN_W'(1) : '0;
   assign run_hit    = dv_ff && (run_next == cnt_ff);
   assign scan_start = PW'(scan_d_ff) + PW'(1) - PW'(cnt_ff);
   assign claim_prod = MW'(start_ff) * MW'(PAGE_BYTES);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (idx_ff == LAST_IDX) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation != OP_CLAIM_RUN) begin
                  state_in = S_DIV_START;
               end else if (req_run_length == '0 || cnt_too_big) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_DIV_START: begin
            if (step_ff) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            priority if (op_ff == OP_SET_RANGE) state_in = S_DIV_END;
            else if (page_bad)                 state_in = S_DONE;
            else if (op_ff == OP_SET_PAGE)     state_in = S_SET;
            else if (op_ff == OP_GET_PAGE)     state_in = S_GET_RD;
            else                               state_in = S_DONE;
         end
         S_SET:      state_in = S_DONE;
         S_GET_RD:   state_in = S_GET_DATA;
         S_GET_DATA: state_in = S_DONE;
         S_DIV_END: begin
            if (step_ff) state_in = S_RANGE_CHK;
         end
         S_RANGE_CHK: begin
            if (page_ff >= last_ff || page_bad) state_in = S_DONE;
            else                                state_in = S_RANGE;
         end
         S_RANGE: begin
            if (ADDR_W'(idx_ff) >= last_ff || idx_ff == NP_IDX) state_in = S_DONE;
         end
         S_SCAN: begin
            priority if (run_hit)                         state_in = S_CLAIM;
            else if (dv_ff && scan_d_ff == AW'(LAST_IDX)) state_in = S_DONE;
            else                                          state_in = S_SCAN;
         end
         S_CLAIM: begin
            if (left_ff == RUN_W'(1)) state_in = S_MUL;
         end
         S_MUL: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath controls and next values.
   always_comb begin
      op_in        = op_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      nst_in       = nst_ff;
      cnt_in       = cnt_ff;
      dq_in        = dq_ff;
      step_in      = step_ff;
      page_in      = page_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      scan_d_in    = scan_d_ff;
      dv_in        = 1'b0;
      run_in       = run_ff;
      start_in     = start_ff;
      left_in      = left_ff;
      res_state_in = res_state_ff;
      res_claim_in = res_claim_ff;
      res_err_in   = res_err_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[AW-1:0];
      mem_wdata    = nst_ff;
      mem_raddr    = idx_ff[AW-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = PS_FREE;
            idx_in    = idx_ff + PW'(1);
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_operation;
               addr_in      = req_address;
               len_in       = req_length;
               nst_in       = req_target_state;
               cnt_in       = req_run_length;
               dq_in        = req_address;
               step_in      = 1'b0;
               idx_in       = '0;
               run_in       = '0;
               res_state_in = '0;
               res_claim_in = '0;
               res_err_in   = (req_operation == OP_CLAIM_RUN && req_run_length != '0 &&
                               cnt_too_big) ? ERR_RANGE : ERR_OK;
            end
         end
         S_DIV_START: begin
            step_in = 1'b1;
            if (step_ff) page_in = div_q;
         end
         S_DISPATCH: begin
            // Set range divides the wrapped end address next.
            dq_in   = addr_ff + len_ff;
            step_in = 1'b0;
            if (op_ff != OP_SET_RANGE && page_bad) res_err_in = ERR_RANGE;
         end
         S_SET: begin
            mem_we    = 1'b1;
            mem_waddr = page_ff[AW-1:0];
         end
         S_GET_RD: begin
            mem_raddr = page_ff[AW-1:0];
         end
         S_GET_DATA: begin
            res_state_in = rd_data_ff;
         end
         S_DIV_END: begin
            step_in = 1'b1;
            if (step_ff) last_in = div_q;
         end
         S_RANGE_CHK: begin
            idx_in = page_ff[PW-1:0];
            if (page_ff < last_ff && page_bad) res_err_in = ERR_RANGE;
         end
         S_RANGE: begin
            if (ADDR_W'(idx_ff) < last_ff) begin
               if (idx_ff == NP_IDX) begin
                  res_err_in = ERR_RANGE;
               end else begin
                  mem_we = 1'b1;
                  idx_in = idx_ff + PW'(1);
               end
            end
         end
         S_SCAN: begin
            // Issue one read per cycle; the data of the previous read is judged here.
            if (idx_ff < NP_IDX) begin
               dv_in  = 1'b1;
               idx_in = idx_ff + PW'(1);
            end
            scan_d_in = idx_ff[AW-1:0];
            if (dv_ff) run_in = run_next;
            if (run_hit) begin
               start_in = scan_start[AW-1:0];
               idx_in   = scan_start;
               left_in  = cnt_ff;
            end else if (dv_ff && scan_d_ff == AW'(LAST_IDX)) begin
               res_err_in = ERR_NORUN;
            end
         end
         S_CLAIM: begin
            mem_we    = 1'b1;
            mem_wdata = PS_USED;
            idx_in    = idx_ff + PW'(1);
            left_in   = left_ff - RUN_W'(1);
         end
         S_MUL: begin
            res_claim_in = ADDR_W'(claim_prod);
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Response register: loaded from the finished result, held while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_state_in = rsp_state_ff;
      rsp_claim_in = rsp_claim_ff;
      rsp_err_in   = rsp_err_ff;
      if (state_ff == S_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_state_in = res_state_ff;
         rsp_claim_in = res_claim_ff;
         rsp_err_in   = res_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      len_ff       <= len_in;
      nst_ff       <= nst_in;
      cnt_ff       <= cnt_in;
      dq_ff        <= dq_in;
      prod_ff      <= prod_in;
      step_ff      <= step_in;
      page_ff      <= page_in;
      last_ff      <= last_in;
      scan_d_ff    <= scan_d_in;
      run_ff       <= run_in;
      start_ff     <= start_in;
      left_ff      <= left_in;
      res_state_ff <= res_state_in;
      res_claim_ff <= res_claim_in;
      res_err_ff   <= res_err_in;
      rsp_state_ff <= rsp_state_in;
      rsp_claim_ff <= rsp_claim_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign req_stall         = !req_take;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_state_read    = rsp_state_ff;
   assign rsp_claim_address = rsp_claim_ff;
   assign rsp_error_code    = rsp_err_ff;

endmodule

`default_nettype wire

// ===== hdl/psma_checker.sv =====
`default_nettype none

module psma_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [psma_pkg::PSTATE_W-1:0] rsp_state_read,
   input wire logic [psma_pkg::ADDR_W-1:0]   rsp_claim_address,
   input wire logic [psma_pkg::ERR_W-1:0]    rsp_error_code
);
   import psma_pkg::*;

   // A response that waits keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_error_code) &&
      $stable(rsp_claim_address) && $stable(rsp_state_read))
      else $error("stalled response changed");

   // Right after reset, in the clearing pass, no request is taken and no response is valid.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("activity right after reset");

   // Only the three defined error codes appear.
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code == ERR_OK || rsp_error_code == ERR_RANGE ||
                    rsp_error_code == ERR_NORUN)
      else $error("undefined error code");

   // A failed operation reports neither a state nor an address.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |-> rsp_claim_address == '0 &&
                                                rsp_state_read == '0)
      else $error("error response carries data");

   // Get answers with a state and claim with an address, never both at once.
   a_one_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_state_read != '0 |-> rsp_claim_address == '0)
      else $error("state and address both set");

endmodule

bind page_state_map_allocator psma_checker u_psma_checker (.*);

`default_nettype wire
